>>> rtl/core/pccs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pccs_pkg
// Shared constants and types for the per-channel contrast stretch block.
// ----------------------------------------------------------------------------
package pccs_pkg;

    localparam int CHANNELS   = 3;
    localparam int LANES      = 3;
    localparam int PIX_W      = 8;
    localparam int NUM_W      = 2 * PIX_W;
    localparam int CH_W       = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int STAT_DEPTH = (CHANNELS < LANES) ? CHANNELS : LANES;
    localparam int STAT_IW    = (STAT_DEPTH > 1) ? $clog2(STAT_DEPTH) : 1;
    localparam int STEP_W     = (PIX_W > 1) ? $clog2(PIX_W) : 1;
    localparam int DATA_W     = ((LANES * PIX_W + 7) / 8) * 8;
    localparam int FUNC_W     = 2;

    localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

    typedef logic [FUNC_W-1:0] t_func;
    localparam t_func FN_CLEAR   = 2'd0;
    localparam t_func FN_ACCUM   = 2'd1;
    localparam t_func FN_STRETCH = 2'd2;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic clear;
        logic accum;
    } t_stat_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage : pccs_pkg
`default_nettype wire

>>> rtl/core/pccs_stats.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pccs_stats
// Per-channel running minimum and maximum with a single read port.
// ----------------------------------------------------------------------------
module pccs_stats (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire pccs_pkg::t_stat_ctl               i_ctl,
    input  wire pccs_pkg::t_pix                    i_px [pccs_pkg::LANES],
    input  wire logic [pccs_pkg::STAT_IW-1:0]      i_rd_idx,
    output logic      [pccs_pkg::PIX_W-1:0]        o_lo,
    output logic      [pccs_pkg::PIX_W-1:0]        o_hi
);
    import pccs_pkg::*;

    t_pix r_min [STAT_DEPTH];
    t_pix r_max [STAT_DEPTH];

    for (genvar g = 0; g < STAT_DEPTH; g++) begin : g_lane
        always_ff @(posedge i_clk) begin
            if (!i_rst_n || i_ctl.clear) begin
                r_min[g] <= PIX_MAX;
                r_max[g] <= '0;
            end else if (i_ctl.accum) begin
                if (i_px[g] < r_min[g]) r_min[g] <= i_px[g];
                if (i_px[g] > r_max[g]) r_max[g] <= i_px[g];
            end
        end
    end

    assign o_lo = r_min[i_rd_idx];
    assign o_hi = r_max[i_rd_idx];

endmodule : pccs_stats
`default_nettype wire

>>> rtl/core/pccs_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pccs_div
// Restoring divider, one quotient bit per cycle, quotient known to fit 8 bits.
// ----------------------------------------------------------------------------
module pccs_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [pccs_pkg::NUM_W-1:0]        i_num,
    input  wire logic [pccs_pkg::PIX_W-1:0]        i_den,
    output pccs_pkg::t_div_sts                     o_sts,
    output logic      [pccs_pkg::PIX_W-1:0]        o_quo
);
    import pccs_pkg::*;

    logic [PIX_W-1:0]  r_rem;
    logic [PIX_W-1:0]  r_low;
    logic [PIX_W-1:0]  r_den;
    logic [PIX_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [PIX_W:0]    trial;
    logic [PIX_W:0]    diff;
    logic              qbit;

    always_comb begin
        trial = {r_rem, r_low[PIX_W-1]};
        diff  = trial - {1'b0, r_den};
        qbit  = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == STEP_W'(PIX_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[NUM_W-1:PIX_W];
            r_low <= i_num[PIX_W-1:0];
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= qbit ? diff[PIX_W-1:0] : trial[PIX_W-1:0];
            r_low <= {r_low[PIX_W-2:0], 1'b0};
            r_quo <= {r_quo[PIX_W-2:0], qbit};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quo      = r_quo;

endmodule : pccs_div
`default_nettype wire

>>> rtl/core/per_channel_contrast_stretch_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// per_channel_contrast_stretch_top
// Min/max contrast stretch of three 8-bit channels with one shared divider.
//
//   channel  direction  tdata                     tuser
//   s        in         blue, green, red (24 b)   func (2 b)
//   m        out        blue, green, red (24 b)   -
//
// Clear and accumulate beats give no output beat.
// A stretch beat walks the channels in turn: a channel that passes through
// or saturates is settled in the setup state, one that goes through the
// divider takes setup, the quotient bits and collect, and a stretch beat
// holds the input from accept until its output is loaded.
// Synchronous active-low reset clears the statistics to min 255, max 0.
// A stalled output register holds the finished pixel; the next input beat
// is taken meanwhile, and a new result waits for the register to free up.
// ----------------------------------------------------------------------------
module per_channel_contrast_stretch_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [pccs_pkg::DATA_W-1:0]   i_s_tdata,   // blue, green, red
    input  wire logic [pccs_pkg::FUNC_W-1:0]   i_s_tuser,   // func
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic      [pccs_pkg::DATA_W-1:0]   o_m_tdata    // blue, green, red
);
    import pccs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SETUP = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_OUT   = 4'b1000
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [CH_W-1:0]   r_ch;
    t_pix              r_px  [LANES];
    t_pix              r_res [LANES];
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;

    t_pix              in_px [LANES];
    t_stat_ctl         stat_ctl;
    t_pix              lo;
    t_pix              hi;
    t_pix              v;
    t_pix              span;
    t_pix              delta;
    logic [NUM_W-1:0]  num;
    logic              active;
    logic              div_start;
    t_div_sts          div_sts;
    t_pix              div_quo;
    logic              accept;
    logic              last_ch;
    logic              out_load;
    t_pix              lane_res;
    logic              lane_fast;

    for (genvar g = 0; g < LANES; g++) begin : g_unpack
        assign in_px[g] = i_s_tdata[g*PIX_W +: PIX_W];
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        stat_ctl.clear = accept && (i_s_tuser == FN_CLEAR);
        stat_ctl.accum = accept && (i_s_tuser == FN_ACCUM);
    end

    pccs_stats u_stats (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (stat_ctl),
        .i_px     (in_px),
        .i_rd_idx (r_ch[STAT_IW-1:0]),
        .o_lo     (lo),
        .o_hi     (hi)
    );

    always_comb begin
        v      = r_px[r_ch];
        active = (r_ch < CH_W'(STAT_DEPTH));
        span   = hi - lo;
        delta  = v - lo;
        num    = {delta, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, delta};
        lane_fast = 1'b1;
        lane_res  = v;
        if (active && (hi > lo)) begin
            if (v <= lo) begin
                lane_res = '0;
            end else if (v >= hi) begin
                lane_res = PIX_MAX;
            end else begin
                lane_fast = 1'b0;
            end
        end
        div_start = (r_state == ST_SETUP) && !lane_fast;
        last_ch   = (r_ch == CH_W'(LANES - 1));
    end

    pccs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num),
        .i_den   (span),
        .o_sts   (div_sts),
        .o_quo   (div_quo)
    );

    assign out_load = (r_state == ST_OUT) && (!r_out_valid || i_m_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_s_tuser == FN_STRETCH)) n_state = ST_SETUP;
            end
            ST_SETUP: begin
                if (!lane_fast)   n_state = ST_DIV;
                else if (last_ch) n_state = ST_OUT;
            end
            ST_DIV: begin
                if (div_sts.done) n_state = last_ch ? ST_OUT : ST_SETUP;
            end
            ST_OUT: begin
                if (out_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ch        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_ch <= '0;
            end else if (((r_state == ST_SETUP) && lane_fast) ||
                         ((r_state == ST_DIV) && div_sts.done)) begin
                r_ch <= r_ch + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px <= in_px;
        end
        if ((r_state == ST_SETUP) && lane_fast) begin
            r_res[r_ch] <= lane_res;
        end else if ((r_state == ST_DIV) && div_sts.done) begin
            r_res[r_ch] <= div_quo;
        end
        if (out_load) begin
            for (int i = 0; i < LANES; i++) begin
                r_out_data[i*PIX_W +: PIX_W] <= r_res[i];
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule : per_channel_contrast_stretch_top
`default_nettype wire

>>> bench/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Checks the per-channel contrast stretch block beat by beat. A directed
// table covers the reset state, empty and inverted ranges, values below
// the minimum and above the maximum, and the unused function code. Random
// frames follow: mostly a clear, a run of accumulate beats, then stretch beats,
// with stray beats mixed in. A local predictor keeps its own copy of the
// per-channel statistics and queues the expected pixel for every accepted
// stretch beat. Both sides of the stream idle at random.
// ----------------------------------------------------------------------------
module tb_top;

    import pccs_pkg::*;

    localparam t_func FN_UNUSED  = 2'd3;
    localparam int    BEAT_GOAL  = 740;
    localparam int    CYCLE_CAP  = 400000;
    localparam int    TAIL_WAIT  = 40;
    localparam int    ROWS       = 21;

    typedef struct packed {
        t_pix red;
        t_pix green;
        t_pix blue;
    } t_rgb;

    typedef struct packed {
        t_func func;
        t_rgb  pix;
        logic  typed;
        t_rgb  want;
    } t_row;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [DATA_W-1:0] i_s_tdata  = '0;   // blue, green, red
    logic [FUNC_W-1:0] i_s_tuser  = '0;   // func
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [DATA_W-1:0] o_m_tdata;         // blue, green, red

    t_pix stat_min [LANES];
    t_pix stat_max [LANES];
    t_rgb pending_pixels [$];
    int   error_count = 0;
    int   beat_count  = 0;
    int   cycle_count = 0;
    bit   quiet       = 1'b0;

    t_row stim_rows [ROWS] = '{
        '{FN_STRETCH, '{8'd255, 8'd128, 8'd0},   1'b1, '{8'd255, 8'd128, 8'd0}},
        '{FN_UNUSED,  '{8'd255, 8'd255, 8'd255}, 1'b0, '0},
        '{FN_ACCUM,   '{8'd0,   8'd0,   8'd0},   1'b0, '0},
        '{FN_STRETCH, '{8'd0,   8'd0,   8'd0},   1'b1, '{8'd0,   8'd0,   8'd0}},
        '{FN_STRETCH, '{8'd200, 8'd1,   8'd90},  1'b1, '{8'd200, 8'd1,   8'd90}},
        '{FN_ACCUM,   '{8'd255, 8'd255, 8'd255}, 1'b0, '0},
        '{FN_STRETCH, '{8'd128, 8'd255, 8'd0},   1'b1, '{8'd128, 8'd255, 8'd0}},
        '{FN_CLEAR,   '{8'd0,   8'd0,   8'd0},   1'b0, '0},
        '{FN_ACCUM,   '{8'd10,  8'd100, 8'd50},  1'b0, '0},
        '{FN_ACCUM,   '{8'd20,  8'd150, 8'd200}, 1'b0, '0},
        '{FN_STRETCH, '{8'd25,  8'd120, 8'd10},  1'b0, '0},
        '{FN_STRETCH, '{8'd15,  8'd150, 8'd50},  1'b0, '0},
        '{FN_UNUSED,  '{8'd0,   8'd0,   8'd0},   1'b0, '0},
        '{FN_STRETCH, '{8'd11,  8'd101, 8'd199}, 1'b0, '0},
        '{FN_ACCUM,   '{8'd5,   8'd255, 8'd0},   1'b0, '0},
        '{FN_STRETCH, '{8'd5,   8'd255, 8'd0},   1'b1, '{8'd0,   8'd255, 8'd0}},
        '{FN_CLEAR,   '{8'd255, 8'd255, 8'd255}, 1'b0, '0},
        '{FN_STRETCH, '{8'd3,   8'd2,   8'd1},   1'b1, '{8'd3,   8'd2,   8'd1}},
        '{FN_ACCUM,   '{8'd77,  8'd77,  8'd77},  1'b0, '0},
        '{FN_STRETCH, '{8'd0,   8'd200, 8'd77},  1'b1, '{8'd0,   8'd200, 8'd77}},
        '{FN_CLEAR,   '{8'd0,   8'd0,   8'd0},   1'b0, '0}
    };

    per_channel_contrast_stretch_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("tb_top failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_m_tready <= quiet || ($urandom_range(99) >= 7);
    end

    task automatic report(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    function automatic t_pix stretch_lane(input int lane, input t_pix v);
        int lo;
        int hi;
        lo = stat_min[lane];
        hi = stat_max[lane];
        if (lane >= CHANNELS || hi <= lo) return v;
        if (v <= lo) return 8'd0;
        if (v >= hi) return PIX_MAX;
        return t_pix'((255 * (int'(v) - lo)) / (hi - lo));
    endfunction

    function automatic t_pix lane_of(input t_rgb p, input int lane);
        case (lane)
            0:       return p.blue;
            1:       return p.green;
            default: return p.red;
        endcase
    endfunction

    task automatic track_beat(input t_func f, input t_rgb p, input logic typed,
                              input t_rgb want);
        t_pix v;
        t_rgb pred;
        case (f)
            FN_CLEAR: begin
                for (int i = 0; i < LANES; i++) begin
                    stat_min[i] = PIX_MAX;
                    stat_max[i] = '0;
                end
            end
            FN_ACCUM: begin
                for (int i = 0; i < LANES && i < CHANNELS; i++) begin
                    v = lane_of(p, i);
                    if (v < stat_min[i]) stat_min[i] = v;
                    if (v > stat_max[i]) stat_max[i] = v;
                end
            end
            FN_STRETCH: begin
                pred.blue  = stretch_lane(0, p.blue);
                pred.green = stretch_lane(1, p.green);
                pred.red   = stretch_lane(2, p.red);
                pending_pixels.push_back(typed ? want : pred);
            end
            default: ;
        endcase
    endtask

    task automatic send_beat(input t_func f, input t_rgb p, input logic typed = 1'b0,
                             input t_rgb want = '0);
        while (!quiet && $urandom_range(99) < 7) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= p;
        i_s_tuser  <= f;
        do @(posedge i_clk); while (!o_s_tready);
        track_beat(f, p, typed, want);
        if (f != FN_UNUSED) beat_count++;
        quiet <= (beat_count >= 300 && beat_count < 450);
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_pix pick_stretch_value(input int lane);
        int lo;
        int hi;
        lo = stat_min[lane];
        hi = stat_max[lane];
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return PIX_MAX;
            2, 3:    return t_pix'($urandom_range(255));
            default: return (hi >= lo) ? t_pix'($urandom_range(hi, lo))
                                       : t_pix'($urandom_range(255));
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_rgb got;
        t_rgb want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata;
            if (pending_pixels.size() == 0) begin
                report($sformatf("output beat %h with nothing pending", got));
            end else begin
                want = pending_pixels.pop_front();
                if (got.blue != want.blue)
                    report($sformatf("blue got %0d want %0d", got.blue, want.blue));
                if (got.green != want.green)
                    report($sformatf("green got %0d want %0d", got.green, want.green));
                if (got.red != want.red)
                    report($sformatf("red got %0d want %0d", got.red, want.red));
            end
        end
    end

    initial begin
        int   base  [LANES];
        int   width [LANES];
        int   n_acc;
        int   n_str;
        t_rgb p;

        for (int i = 0; i < LANES; i++) begin
            stat_min[i] = PIX_MAX;
            stat_max[i] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[k])
            send_beat(stim_rows[k].func, stim_rows[k].pix, stim_rows[k].typed,
                      stim_rows[k].want);
        drain_results();

        while (beat_count < BEAT_GOAL) begin
            if ($urandom_range(9) != 0) begin
                p = 24'($urandom);
                send_beat(FN_CLEAR, p);
            end
            for (int i = 0; i < LANES; i++) begin
                base[i]  = $urandom_range(255);
                width[i] = ($urandom_range(3) == 0) ? 0 : $urandom_range(255 - base[i]);
            end
            n_acc = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(6, 1);
            repeat (n_acc) begin
                p.blue  = t_pix'($urandom_range(base[0] + width[0], base[0]));
                p.green = t_pix'($urandom_range(base[1] + width[1], base[1]));
                p.red   = t_pix'($urandom_range(base[2] + width[2], base[2]));
                if ($urandom_range(9) == 0) p = 24'($urandom);
                send_beat(FN_ACCUM, p);
            end
            if ($urandom_range(19) == 0) begin
                p = 24'($urandom);
                send_beat(FN_UNUSED, p);
            end
            n_str = $urandom_range(10, 1);
            repeat (n_str) begin
                if ($urandom_range(29) == 0) begin
                    p = 24'($urandom);
                    send_beat(FN_ACCUM, p);
                end else begin
                    p.blue  = pick_stretch_value(0);
                    p.green = pick_stretch_value(1);
                    p.red   = pick_stretch_value(2);
                    send_beat(FN_STRETCH, p);
                end
            end
        end

        drain_results();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (pending_pixels.size() != 0)
            report($sformatf("%0d pixels never came out", pending_pixels.size()));
        if (error_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule : tb_top
`default_nettype wire
